/* design/ddi_pkg.sv */
// ddi_pkg: shared types and constants for the duplicate-free ordered list
// used by ddi_cell and dedup_deque_insert_top; no dependencies
`default_nettype none

package ddi_pkg;

  localparam int CAPACITY_DEF = 16;
  localparam int IDX_W        = 9;
  localparam int VAL_W        = 32;
  localparam int POS_W        = 4;
  localparam int LEN_W        = 5;
  localparam int STAT_W       = 3;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_READ   = 1'b1
  } action_t;

  typedef enum logic [STAT_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_READ_OK   = 3'd3,
    ST_READ_OOR  = 3'd4
  } status_t;

  typedef struct packed {
    logic                    action;
    logic signed [VAL_W-1:0] value;
    logic                    at_front;
    logic [POS_W-1:0]        position;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] read_value;
    logic [LEN_W-1:0]        length;
  } out_t;

  typedef struct packed {
    logic             push_front;
    logic             push_back;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
  } cell_ctl_t;

endpackage

`default_nettype wire

/* design/ddi_cell.sv */
// ddi_cell: one list position, holds an entry and shifts toward the back
// depends on ddi_pkg
`default_nettype none

module ddi_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic                          clk,
  input  wire ddi_pkg::cell_ctl_t            ctl,
  input  wire logic [CNT_W-1:0]              count,
  input  wire logic [ddi_pkg::VAL_W-1:0]     left_data,
  output logic      [ddi_pkg::VAL_W-1:0]     data,
  output logic                               match,
  output logic      [ddi_pkg::VAL_W-1:0]     rd_data
);

  localparam logic [CNT_W-1:0]          IdxC = CNT_W'(IDX);
  localparam logic [ddi_pkg::IDX_W-1:0] IdxP = ddi_pkg::IDX_W'(IDX);

  logic [ddi_pkg::VAL_W-1:0] data_r;
  logic [ddi_pkg::VAL_W-1:0] data_nxt;
  logic                      occ;
  logic                      sel;

  assign occ  = IdxC < count;
  assign sel  = ddi_pkg::IDX_W'(ctl.position) == IdxP;
  assign data = data_r;
  assign match   = occ && (data_r == ctl.value);
  assign rd_data = (occ && sel) ? data_r : '0;

  always_comb begin
    data_nxt = data_r;
    if (ctl.push_front) begin
      data_nxt = left_data;
    end else if (ctl.push_back && (IdxC == count)) begin
      data_nxt = ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

`default_nettype wire

/* design/dedup_deque_insert_top.sv */
// dedup_deque_insert_top: duplicate-free ordered list built from a row of cells
// depends on ddi_pkg and ddi_cell
`default_nettype none

// Bounded ordered list of signed 32-bit values that refuses duplicates. Entry
// i of the list lives in cell i; a front insert shifts every cell one place
// toward the back, a back insert writes the first free cell. Every cell
// compares its entry with the incoming value in the same cycle, so each
// transaction (insert or positional read) is decided combinationally and its
// result lands in the output register on the next edge. One transaction is
// taken per clock as long as the output register is empty or is being
// drained in that cycle; the result register is the only pipeline stage.
// No clearing pass is needed after reset.

module dedup_deque_insert_top #(
  parameter int CAPACITY = ddi_pkg::CAPACITY_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire ddi_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ddi_pkg::out_t      out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CapC = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic                      out_valid_nxt;
  ddi_pkg::out_t             out_data_r;
  ddi_pkg::out_t             out_data_nxt;
  ddi_pkg::cell_ctl_t        ctl;
  logic                      acc;
  logic                      dup;
  logic                      full;
  logic                      ins_ok;
  logic                      rd_in;
  logic [ddi_pkg::VAL_W-1:0] rd_or;
  ddi_pkg::status_t          status;

  logic [ddi_pkg::VAL_W-1:0] cell_data [CAPACITY];
  logic [ddi_pkg::VAL_W-1:0] cell_rd   [CAPACITY];
  logic [CAPACITY-1:0]       cell_match;

  assign acc      = in_valid && in_ready;
  assign in_ready = !out_valid_r || out_ready;

  assign dup    = |cell_match;
  assign full   = count_r >= CapC;
  assign rd_in  = ddi_pkg::IDX_W'(in_data.position) < ddi_pkg::IDX_W'(count_r);
  assign ins_ok = acc && (in_data.action == ddi_pkg::ACT_INSERT) && !dup && !full;

  assign ctl.push_front = ins_ok && in_data.at_front;
  assign ctl.push_back  = ins_ok && !in_data.at_front;
  assign ctl.value      = in_data.value;
  assign ctl.position   = in_data.position;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [ddi_pkg::VAL_W-1:0] left_w;
      if (gi == 0) begin : g_head
        assign left_w = in_data.value;
      end else begin : g_body
        assign left_w = cell_data[gi-1];
      end
      ddi_cell #(
        .IDX   (gi),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .count     (count_r),
        .left_data (left_w),
        .data      (cell_data[gi]),
        .match     (cell_match[gi]),
        .rd_data   (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_comb begin
    if (in_data.action == ddi_pkg::ACT_READ) begin
      status = rd_in ? ddi_pkg::ST_READ_OK : ddi_pkg::ST_READ_OOR;
    end else if (dup) begin
      status = ddi_pkg::ST_DUPLICATE;
    end else if (full) begin
      status = ddi_pkg::ST_FULL;
    end else begin
      status = ddi_pkg::ST_INSERTED;
    end
  end

  always_comb begin
    count_nxt     = ins_ok ? count_r + CNT_W'(1) : count_r;
    out_valid_nxt = acc || (out_valid_r && !out_ready);
    out_data_nxt  = out_data_r;
    if (acc) begin
      out_data_nxt.status     = status;
      out_data_nxt.read_value = (status == ddi_pkg::ST_READ_OK) ? rd_or : '0;
      out_data_nxt.length     = ddi_pkg::LEN_W'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CapC)
    else $error("entry count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ins_ok |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("successful insert did not grow the list");

  a_refused_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && !ins_ok) |=> $stable(count_r))
    else $error("list length changed without an insert");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> out_valid)
    else $error("accepted transaction produced no result");
`endif

endmodule

`default_nettype wire

/* sim/tb_top.sv */
// tb_top: self-checking bench for dedup_deque_insert_top, directed table then random traffic
// depends on ddi_pkg and dedup_deque_insert_top; expected results: table or local list model
`timescale 1ns / 100ps

module tb_top;

  localparam int CAP            = ddi_pkg::CAPACITY_DEF;
  localparam int RAND_ITEMS     = 675;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct {
    ddi_pkg::in_t  item;
    bit            typed;
    ddi_pkg::out_t want;
  } row_t;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  ddi_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  ddi_pkg::out_t out_data;

  logic signed [ddi_pkg::VAL_W-1:0] list_cells [CAP];
  int            list_head;
  int            list_len;
  ddi_pkg::out_t results_due [$];
  row_t          plan [$];
  ddi_pkg::out_t got;
  ddi_pkg::out_t want;
  int            errors;
  int            idle_cycles;
  bit            hold_req;
  bit            hold_done;
  bit            calm;

  dedup_deque_insert_top #(
    .CAPACITY (CAP)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ring of cells with head index and length, updated once per accepted transaction
  function automatic ddi_pkg::out_t list_apply(input ddi_pkg::in_t item);
    ddi_pkg::out_t res;
    bit            found;
    res   = '0;
    found = 1'b0;
    if (item.action == ddi_pkg::ACT_INSERT) begin
      for (int i = 0; i < list_len; i++) begin
        if (list_cells[(list_head + i) % CAP] == item.value) found = 1'b1;
      end
      if (found) begin
        res.status = ddi_pkg::ST_DUPLICATE;
      end else if (list_len >= CAP) begin
        res.status = ddi_pkg::ST_FULL;
      end else begin
        if (item.at_front) begin
          list_head = (list_head + CAP - 1) % CAP;
          list_cells[list_head] = item.value;
        end else begin
          list_cells[(list_head + list_len) % CAP] = item.value;
        end
        list_len++;
        res.status = ddi_pkg::ST_INSERTED;
      end
    end else begin
      if (int'(item.position) < list_len) begin
        res.read_value = list_cells[(list_head + int'(item.position)) % CAP];
        res.status     = ddi_pkg::ST_READ_OK;
      end else begin
        res.status = ddi_pkg::ST_READ_OOR;
      end
    end
    res.length = ddi_pkg::LEN_W'(list_len);
    return res;
  endfunction

  function automatic ddi_pkg::in_t mk_ins(input logic signed [ddi_pkg::VAL_W-1:0] v,
                                          input logic front);
    ddi_pkg::in_t t;
    t.action   = ddi_pkg::ACT_INSERT;
    t.value    = v;
    t.at_front = front;
    t.position = v[ddi_pkg::POS_W-1:0];
    return t;
  endfunction

  function automatic ddi_pkg::in_t mk_rd(input logic [ddi_pkg::POS_W-1:0] pos);
    ddi_pkg::in_t t;
    t.action   = ddi_pkg::ACT_READ;
    t.value    = {8{pos}};
    t.at_front = pos[0];
    t.position = pos;
    return t;
  endfunction

  function automatic ddi_pkg::out_t mk_res(input ddi_pkg::status_t st,
                                           input logic signed [ddi_pkg::VAL_W-1:0] rd,
                                           input logic [ddi_pkg::LEN_W-1:0] len);
    ddi_pkg::out_t r;
    r.status     = st;
    r.read_value = rd;
    r.length     = len;
    return r;
  endfunction

  function automatic void add_row(input ddi_pkg::in_t item, input bit typed,
                                  input ddi_pkg::out_t want_res);
    row_t r;
    r.item  = item;
    r.typed = typed;
    r.want  = want_res;
    plan.push_back(r);
  endfunction

  function automatic ddi_pkg::in_t random_item();
    ddi_pkg::in_t t;
    t.value    = $urandom;
    t.at_front = 1'($urandom_range(0, 1));
    t.position = ddi_pkg::POS_W'($urandom_range(0, 15));
    if ($urandom_range(0, 1) == 1) begin
      t.action = ddi_pkg::ACT_READ;
    end else begin
      t.action = ddi_pkg::ACT_INSERT;
      // when the list is not empty, half the inserts reuse a stored value to hit the duplicate path
      if (list_len > 0 && $urandom_range(0, 1) == 1)
        t.value = list_cells[(list_head + $urandom_range(0, list_len - 1)) % CAP];
    end
    return t;
  endfunction

  task automatic offer(input ddi_pkg::in_t item, input bit typed,
                       input ddi_pkg::out_t typed_res);
    ddi_pkg::out_t pred;
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    pred = list_apply(item);
    results_due.push_back(typed ? typed_res : pred);
  endtask

  initial begin : drive
    in_valid  <= 1'b0;
    in_data   <= '0;
    rst_n     <= 1'b0;
    list_head = 0;
    list_len  = 0;
    errors    = 0;
    hold_req  = 1'b0;
    hold_done = 1'b0;
    calm      = 1'b0;

    add_row(mk_rd(4'd0), 1'b1, mk_res(ddi_pkg::ST_READ_OOR, 32'sd0, 5'd0));
    add_row(mk_rd(4'd15), 1'b1, mk_res(ddi_pkg::ST_READ_OOR, 32'sd0, 5'd0));
    add_row(mk_ins(32'sd0, 1'b0), 1'b1, mk_res(ddi_pkg::ST_INSERTED, 32'sd0, 5'd1));
    add_row(mk_ins(32'h7FFF_FFFF, 1'b1), 1'b1, mk_res(ddi_pkg::ST_INSERTED, 32'sd0, 5'd2));
    add_row(mk_ins(32'h8000_0000, 1'b0), 1'b1, mk_res(ddi_pkg::ST_INSERTED, 32'sd0, 5'd3));
    add_row(mk_ins(32'sd0, 1'b1), 1'b1, mk_res(ddi_pkg::ST_DUPLICATE, 32'sd0, 5'd3));
    add_row(mk_rd(4'd0), 1'b1, mk_res(ddi_pkg::ST_READ_OK, 32'h7FFF_FFFF, 5'd3));
    add_row(mk_rd(4'd2), 1'b1, mk_res(ddi_pkg::ST_READ_OK, 32'h8000_0000, 5'd3));
    add_row(mk_rd(4'd3), 1'b1, mk_res(ddi_pkg::ST_READ_OOR, 32'sd0, 5'd3));
    add_row(mk_ins(32'hFFFF_FFFF, 1'b1), 1'b1, mk_res(ddi_pkg::ST_INSERTED, 32'sd0, 5'd4));
    add_row(mk_ins(32'h0000_0001, 1'b0), 1'b0, '0);
    add_row(mk_ins(32'h5555_5555, 1'b1), 1'b0, '0);
    add_row(mk_ins(32'hAAAA_AAAA, 1'b0), 1'b0, '0);
    add_row(mk_ins(32'hFFFF_FFFE, 1'b1), 1'b0, '0);
    add_row(mk_ins(32'h0000_FFFF, 1'b0), 1'b0, '0);
    add_row(mk_ins(32'hFFFF_0000, 1'b1), 1'b0, '0);
    add_row(mk_ins(32'h1234_5678, 1'b0), 1'b0, '0);
    add_row(mk_ins(32'h8765_4321, 1'b1), 1'b0, '0);
    add_row(mk_ins(32'h7FFF_FFFE, 1'b0), 1'b0, '0);
    add_row(mk_ins(32'h8000_0001, 1'b1), 1'b0, '0);
    add_row(mk_ins(32'h0F0F_0F0F, 1'b0), 1'b0, '0);
    add_row(mk_ins(32'hF0F0_F0F0, 1'b1), 1'b0, '0);
    add_row(mk_ins(32'h0BAD_F00D, 1'b0), 1'b1, mk_res(ddi_pkg::ST_FULL, 32'sd0, 5'd16));
    add_row(mk_ins(32'h8000_0000, 1'b1), 1'b1, mk_res(ddi_pkg::ST_DUPLICATE, 32'sd0, 5'd16));
    add_row(mk_rd(4'd15), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (plan[i]) offer(plan[i].item, plan[i].typed, plan[i].want);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n == 250) hold_req = 1'b1;
      if (n == RAND_ITEMS - 100) calm = 1'b1;
      offer(random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : drain
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        // long back-pressure so the block fills and stalls its input
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      got = out_data;
      if (results_due.size() == 0) begin
        $display("%0t: unexpected transaction, status %0d read_value %0d length %0d",
                 $time, got.status, got.read_value, got.length);
        errors++;
      end else begin
        want = results_due.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.read_value !== want.read_value) begin
          $display("%0t: read_value expected %0d got %0d",
                   $time, want.read_value, got.read_value);
          errors++;
        end
        if (got.length !== want.length) begin
          $display("%0t: length expected %0d got %0d", $time, want.length, got.length);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("Some tests failed");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule

/* filelist.f */
design/ddi_pkg.sv
design/ddi_cell.sv
design/dedup_deque_insert_top.sv
sim/tb_top.sv
